// ===== src/ucrr_pkg.sv =====
// Package: shared types and constants for the USB control request responder.
`default_nettype none
package ucrr_pkg;

    // Setup packet fields.
    typedef struct packed {
        logic [7:0]  request_type;
        logic [7:0]  request_code;
        logic [15:0] request_value;
        logic [15:0] request_length;
    } t_req;

    // One result item.
    typedef struct packed {
        logic [1:0] reply_kind;
        logic [7:0] data_byte;
        logic       packet_end;
        logic       last;
        logic [6:0] device_address_out;
        logic       address_enabled_out;
        logic       configured_out;
        logic       endpoints_enabled_out;
    } t_rsp;

    // Reply kinds
    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_ZLP   = 2'd1;
    localparam logic [1:0] KIND_STALL = 2'd2;

    // Requests, {bRequest, bmRequestType}
    localparam logic [15:0] REQ_GET_DESC = 16'h0680;
    localparam logic [15:0] REQ_SET_ADDR = 16'h0500;
    localparam logic [15:0] REQ_SET_CFG  = 16'h0900;
    localparam logic [15:0] REQ_CLR_FEAT = 16'h0101;

    // Descriptor selectors in wValue
    localparam logic [15:0] DVAL_DEVICE   = 16'h0100;
    localparam logic [15:0] DVAL_CONFIG   = 16'h0200;
    localparam logic [15:0] DVAL_TYPE_MSK = 16'h0F00;
    localparam logic [15:0] DVAL_STRING   = 16'h0300;
    localparam logic [7:0]  STR_IDX_LANG  = 8'd0;
    localparam logic [7:0]  STR_IDX_SER   = 8'd1;

    // Configuration register indexes
    localparam int         CFG_IDX_W       = 1;
    localparam logic [0:0] CFG_VENDOR_ID  = 1'd0;
    localparam logic [0:0] CFG_PRODUCT_ID = 1'd1;
    localparam logic [15:0] VENDOR_ID_RST  = 16'h0694;
    localparam logic [15:0] PRODUCT_ID_RST = 16'h0002;

    // Descriptor ROM layout
    localparam int ROM_DEPTH = 80;
    localparam int ROM_AW    = 7;
    localparam logic [ROM_AW-1:0] DEV_BASE  = 7'd0;
    localparam logic [ROM_AW-1:0] CFG_BASE  = 7'd18;
    localparam logic [ROM_AW-1:0] LANG_BASE = 7'd50;
    localparam logic [ROM_AW-1:0] SER_BASE  = 7'd54;

    // Lengths (6 bits holds the longest, 32)
    localparam logic [5:0] DEV_LEN  = 6'd18;
    localparam logic [5:0] CFG_LEN  = 6'd32;
    localparam logic [5:0] LANG_LEN = 6'd4;
    localparam logic [5:0] SER_LEN  = 6'd26;

    // Device descriptor bytes patched at run time
    localparam logic [4:0] DEV_IDX_MPS   = 5'd7;
    localparam logic [4:0] DEV_IDX_VID_L = 5'd8;
    localparam logic [4:0] DEV_IDX_VID_H = 5'd9;
    localparam logic [4:0] DEV_IDX_PID_L = 5'd10;
    localparam logic [4:0] DEV_IDX_PID_H = 5'd11;

    localparam logic [7:0] DESC_ROM [0:ROM_DEPTH-1] = '{
        // device (bytes 7..11 patched)
        8'h12, 8'h01, 8'h00, 8'h02, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h01,
        // configuration
        8'h09, 8'h02, 8'h20, 8'h00, 8'h01, 8'h01, 8'h00, 8'hC0, 8'h00,
        8'h09, 8'h04, 8'h00, 8'h00, 8'h02, 8'hFF, 8'hFF, 8'hFF, 8'h00,
        8'h07, 8'h05, 8'h01, 8'h02, 8'h40, 8'h00, 8'h00,
        8'h07, 8'h05, 8'h82, 8'h02, 8'h40, 8'h00, 8'h00,
        // language string
        8'h04, 8'h03, 8'h09, 8'h04,
        // serial string
        8'h1A, 8'h03,
        8'h31, 8'h00, 8'h32, 8'h00, 8'h33, 8'h00, 8'h34, 8'h00,
        8'h35, 8'h00, 8'h36, 8'h00, 8'h37, 8'h00, 8'h38, 8'h00,
        8'h30, 8'h00, 8'h30, 8'h00, 8'h39, 8'h00, 8'h30, 8'h00
    };

endpackage
`default_nettype wire

// ===== src/usb_control_request_responder_unit.sv =====
// Top level: USB control endpoint responder for enumeration requests.
`default_nettype none
// Takes one setup packet per item and answers with a run of result items:
// descriptor bytes grouped into packets of PACKET_BYTES, a zero-length packet
// or a stall. Descriptor contents sit in a ROM with a registered read port;
// the read address runs one byte ahead of the output register so that a
// descriptor streams out at one byte per cycle while the sink is ready.
// A setup item yields 1 to 33 results; the ROM read loop sets the
// one-byte-per-cycle streaming rate. The next setup is accepted as soon as the
// last result of the current one sits in the output register. Address and
// configuration state updates at accept time, and every result of a request
// carries the state after that request. vendor_id/product_id are written
// through the plain config port (index 0 and 1); the user must write them only
// while idle, as the block itself does not enforce it.
module usb_control_request_responder_unit #(
    parameter int PACKET_BYTES = 8
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // setup items
    input  wire logic                          i_req_valid,
    output      logic                          o_req_ready,
    input  wire ucrr_pkg::t_req                i_req,
    // result items
    output      logic                          o_rsp_valid,
    input  wire logic                          i_rsp_ready,
    output      ucrr_pkg::t_rsp                o_rsp,
    // config writes
    input  wire logic                          i_cfg_we,
    input  wire logic [ucrr_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [15:0]                   i_cfg_data
);
    import ucrr_pkg::*;

    localparam int PKT_W = $clog2(PACKET_BYTES);

    typedef enum logic [1:0] {S_IDLE, S_DATA, S_TAIL} t_state;

    // control and status registers
    t_state              r_state,    n_state;
    logic [ROM_AW-1:0]   r_base,     n_base;
    logic [5:0]          r_len,      n_len;
    logic [4:0]          r_idx,      n_idx;
    logic [PKT_W-1:0]    r_pkt,      n_pkt;
    logic                r_tail,     n_tail;
    logic [1:0]          r_tkind,    n_tkind;
    logic                r_rsp_valid, n_rsp_valid;
    t_rsp                r_rsp,      n_rsp;
    logic [6:0]          r_dev_addr, n_dev_addr;
    logic                r_addr_en,  n_addr_en;
    logic                r_cfgd,     n_cfgd;
    logic                r_ep_en,    n_ep_en;
    logic [15:0]         r_vid,      r_pid;
    logic [7:0]          r_rom_q;

    // decode of the incoming setup
    logic [15:0]         req_code;
    logic                accept;
    logic                load;
    logic                d_data;
    logic [ROM_AW-1:0]   d_base;
    logic [5:0]          d_len;
    logic                d_tail;
    logic [1:0]          d_kind;
    logic [5:0]          rd_idx;
    logic [ROM_AW-1:0]   rd_addr;
    logic                last_byte;
    logic [7:0]          byte_out;

    assign req_code    = {i_req.request_code, i_req.request_type};
    assign accept      = i_req_valid && (r_state == S_IDLE);
    assign load        = (r_state != S_IDLE) && (!r_rsp_valid || i_rsp_ready);
    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    always_comb begin
        d_data = 1'b0;
        d_base = DEV_BASE;
        d_len  = DEV_LEN;
        d_tail = 1'b0;
        d_kind = KIND_STALL;
        unique case (req_code)
            REQ_GET_DESC: begin
                if (i_req.request_value == DVAL_DEVICE) begin
                    d_data = 1'b1;
                end else if (i_req.request_value == DVAL_CONFIG) begin
                    d_base = CFG_BASE;
                    // clip to wLength; empty data stage becomes a ZLP
                    if (i_req.request_length < 16'(CFG_LEN)) begin
                        d_len = i_req.request_length[5:0];
                    end else begin
                        d_len = CFG_LEN;
                    end
                    d_data = (i_req.request_length != 16'd0);
                    d_tail = (i_req.request_length > 16'(CFG_LEN));
                    d_kind = KIND_ZLP;
                end else if ((i_req.request_value & DVAL_TYPE_MSK) == DVAL_STRING) begin
                    if (i_req.request_value[7:0] == STR_IDX_LANG) begin
                        d_data = 1'b1;
                        d_base = LANG_BASE;
                        d_len  = LANG_LEN;
                    end else if (i_req.request_value[7:0] == STR_IDX_SER) begin
                        d_data = 1'b1;
                        d_base = SER_BASE;
                        d_len  = SER_LEN;
                    end
                end
            end
            REQ_SET_ADDR, REQ_SET_CFG, REQ_CLR_FEAT: d_kind = KIND_ZLP;
            default: d_kind = KIND_STALL;
        endcase
    end

    // ROM read runs one byte ahead: r_rom_q always holds byte r_idx
    always_comb begin
        rd_idx = {1'b0, r_idx};
        if ((r_state == S_DATA) && load) begin
            rd_idx = {1'b0, r_idx} + 6'd1;
        end
        if (accept) begin
            rd_addr = d_base;
        end else begin
            rd_addr = r_base + ROM_AW'(rd_idx);
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_addr < ROM_AW'(ROM_DEPTH)) begin
            r_rom_q <= DESC_ROM[rd_addr];
        end else begin
            r_rom_q <= 8'h00;
        end
    end

    // patch run-time fields of the device descriptor
    always_comb begin
        byte_out = r_rom_q;
        if (r_base == DEV_BASE) begin
            case (r_idx)
                DEV_IDX_MPS:   byte_out = 8'(PACKET_BYTES);
                DEV_IDX_VID_L: byte_out = r_vid[7:0];
                DEV_IDX_VID_H: byte_out = r_vid[15:8];
                DEV_IDX_PID_L: byte_out = r_pid[7:0];
                DEV_IDX_PID_H: byte_out = r_pid[15:8];
                default:       byte_out = r_rom_q;
            endcase
        end
    end

    assign last_byte = (({1'b0, r_idx} + 6'd1) == r_len);

    always_comb begin
        n_state     = r_state;
        n_base      = r_base;
        n_len       = r_len;
        n_idx       = r_idx;
        n_pkt       = r_pkt;
        n_tail      = r_tail;
        n_tkind     = r_tkind;
        n_rsp_valid = r_rsp_valid;
        n_rsp       = r_rsp;
        n_dev_addr  = r_dev_addr;
        n_addr_en   = r_addr_en;
        n_cfgd      = r_cfgd;
        n_ep_en     = r_ep_en;

        if (r_rsp_valid && i_rsp_ready) begin
            n_rsp_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_base  = d_base;
                    n_len   = d_len;
                    n_idx   = 5'd0;
                    n_pkt   = '0;
                    n_tail  = d_tail;
                    n_tkind = d_kind;
                    n_state = d_data ? S_DATA : S_TAIL;
                    if (req_code == REQ_SET_ADDR) begin
                        n_dev_addr = i_req.request_value[6:0];
                        n_addr_en  = (i_req.request_value[6:0] != 7'd0);
                    end
                    if (req_code == REQ_SET_CFG) begin
                        n_cfgd  = 1'b1;
                        n_ep_en = (i_req.request_value != 16'd0);
                    end
                end
            end
            S_DATA: begin
                if (load) begin
                    n_rsp_valid      = 1'b1;
                    n_rsp.reply_kind = KIND_DATA;
                    n_rsp.data_byte  = byte_out;
                    n_rsp.packet_end = last_byte ||
                                       (r_pkt == PKT_W'(PACKET_BYTES - 1));
                    n_rsp.last       = last_byte && !r_tail;
                    n_idx            = r_idx + 5'd1;
                    if (r_pkt == PKT_W'(PACKET_BYTES - 1)) begin
                        n_pkt = '0;
                    end else begin
                        n_pkt = r_pkt + PKT_W'(1);
                    end
                    if (last_byte) begin
                        n_tkind = KIND_ZLP;
                        n_state = r_tail ? S_TAIL : S_IDLE;
                    end
                end
            end
            S_TAIL: begin
                if (load) begin
                    n_rsp_valid      = 1'b1;
                    n_rsp.reply_kind = r_tkind;
                    n_rsp.data_byte  = 8'h00;
                    n_rsp.packet_end = 1'b0;
                    n_rsp.last       = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // status after the current request rides on every result
        n_rsp.device_address_out    = r_dev_addr;
        n_rsp.address_enabled_out   = r_addr_en;
        n_rsp.configured_out        = r_cfgd;
        n_rsp.endpoints_enabled_out = r_ep_en;
        if (!load) begin
            n_rsp.device_address_out    = r_rsp.device_address_out;
            n_rsp.address_enabled_out   = r_rsp.address_enabled_out;
            n_rsp.configured_out        = r_rsp.configured_out;
            n_rsp.endpoints_enabled_out = r_rsp.endpoints_enabled_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rsp_valid <= 1'b0;
            r_dev_addr  <= 7'd0;
            r_addr_en   <= 1'b0;
            r_cfgd      <= 1'b0;
            r_ep_en     <= 1'b0;
            r_idx       <= 5'd0;
            r_pkt       <= '0;
            r_tail      <= 1'b0;
            r_tkind     <= KIND_STALL;
            r_vid       <= VENDOR_ID_RST;
            r_pid       <= PRODUCT_ID_RST;
        end else begin
            r_state     <= n_state;
            r_rsp_valid <= n_rsp_valid;
            r_dev_addr  <= n_dev_addr;
            r_addr_en   <= n_addr_en;
            r_cfgd      <= n_cfgd;
            r_ep_en     <= n_ep_en;
            r_idx       <= n_idx;
            r_pkt       <= n_pkt;
            r_tail      <= n_tail;
            r_tkind     <= n_tkind;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_VENDOR_ID:  r_vid <= i_cfg_data;
                    CFG_PRODUCT_ID: r_pid <= i_cfg_data;
                    default: ;
                endcase
            end
        end
        r_base <= n_base;
        r_len  <= n_len;
        r_rsp  <= n_rsp;
    end

endmodule
`default_nettype wire

// ===== bench/tb_usb_control_request_responder_unit.sv =====
// Testbench for the USB control request responder: directed table, random setups, scoreboard.
`timescale 1ns / 100ps
module tb_usb_control_request_responder_unit;
    import ucrr_pkg::*;

    // Bytes per packet; the same value goes to the block's parameter.
    localparam int PKT_BYTES = 8;

    // Descriptor contents as the host should see them. Device bytes 7..11 are
    // filled in at prediction time: packet size, vendor id, product id.
    localparam logic [7:0] DEV_TMPL [0:17] = '{
        8'h12, 8'h01, 8'h00, 8'h02, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h01
    };
    localparam logic [7:0] CFG_BYTES [0:31] = '{
        8'h09, 8'h02, 8'h20, 8'h00, 8'h01, 8'h01, 8'h00, 8'hC0, 8'h00,
        8'h09, 8'h04, 8'h00, 8'h00, 8'h02, 8'hFF, 8'hFF, 8'hFF, 8'h00,
        8'h07, 8'h05, 8'h01, 8'h02, 8'h40, 8'h00, 8'h00,
        8'h07, 8'h05, 8'h82, 8'h02, 8'h40, 8'h00, 8'h00
    };
    localparam logic [7:0] LANG_BYTES [0:3] = '{8'h04, 8'h03, 8'h09, 8'h04};
    localparam logic [7:0] SER_BYTES [0:25] = '{
        8'h1A, 8'h03,
        8'h31, 8'h00, 8'h32, 8'h00, 8'h33, 8'h00, 8'h34, 8'h00,
        8'h35, 8'h00, 8'h36, 8'h00, 8'h37, 8'h00, 8'h38, 8'h00,
        8'h30, 8'h00, 8'h30, 8'h00, 8'h39, 8'h00, 8'h30, 8'h00
    };

    // Single-result replies whose every field is known while all state is
    // still at its reset value.
    localparam t_rsp STALL_AT_RESET = '{KIND_STALL, 8'h00, 1'b0, 1'b1, 7'd0, 1'b0, 1'b0, 1'b0};
    localparam t_rsp ZLP_AT_RESET   = '{KIND_ZLP, 8'h00, 1'b0, 1'b1, 7'd0, 1'b0, 1'b0, 1'b0};

    typedef enum logic [2:0] {
        DESC_NONE, DESC_DEVICE, DESC_CONFIG, DESC_LANG, DESC_SERIAL
    } t_desc_sel;

    // One row of the directed table: the setup item and, where it can be read
    // off directly, the whole reply typed in.
    typedef struct {
        t_req rq;
        bit   typed;
        t_rsp want;
    } t_row;

    // DUT ports; the inputs are known from time zero
    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_req_valid = 1'b0;
    logic                 o_req_ready;
    t_req                 i_req       = '0;
    logic                 o_rsp_valid;
    logic                 i_rsp_ready = 1'b0;
    t_rsp                 o_rsp;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx   = '0;
    logic [15:0]          i_cfg_data  = '0;

    // Shadow of the block's state and registers
    logic [6:0]  addr_now       = 7'd0;
    logic        addr_on        = 1'b0;
    logic        configured_now = 1'b0;
    logic        eps_on         = 1'b0;
    logic [15:0] vid_now        = VENDOR_ID_RST;
    logic [15:0] pid_now        = PRODUCT_ID_RST;

    t_rsp reply_run[$];        // reply of the setup just accepted
    t_rsp pending_replies[$];  // result items still owed by the block
    int   mismatches    = 0;
    int   replies_seen  = 0;
    bit   steady        = 1'b0;  // both sides run without gaps while set
    bit   hold_rsp_long = 1'b0;  // next sink stall is a long one

    usb_control_request_responder_unit #(
        .PACKET_BYTES(PKT_BYTES)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_req_valid(i_req_valid),
        .o_req_ready(o_req_ready),
        .i_req(i_req),
        .o_rsp_valid(o_rsp_valid),
        .i_rsp_ready(i_rsp_ready),
        .o_rsp(o_rsp),
        .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Build a setup item from a {bRequest, bmRequestType} pair.
    function automatic t_req setup(input logic [15:0] req, input logic [15:0] value,
                                   input logic [15:0] length);
        t_req rq;
        rq.request_type   = req[7:0];
        rq.request_code   = req[15:8];
        rq.request_value  = value;
        rq.request_length = length;
        return rq;
    endfunction

    function automatic logic [7:0] desc_byte(input t_desc_sel sel, input int idx);
        case (sel)
            DESC_DEVICE: begin
                case (idx)
                    DEV_IDX_MPS:   return 8'(PKT_BYTES);
                    DEV_IDX_VID_L: return vid_now[7:0];
                    DEV_IDX_VID_H: return vid_now[15:8];
                    DEV_IDX_PID_L: return pid_now[7:0];
                    DEV_IDX_PID_H: return pid_now[15:8];
                    default:       return DEV_TMPL[idx];
                endcase
            end
            DESC_CONFIG: return CFG_BYTES[idx];
            DESC_LANG:   return LANG_BYTES[idx];
            DESC_SERIAL: return SER_BYTES[idx];
            default:     return 8'h00;
        endcase
    endfunction

    // Works out the reply of one setup item into reply_run and moves the
    // shadow state on. Every result carries the state after the request.
    task automatic predict_reply(input t_req rq);
        logic [15:0] code;
        t_desc_sel   sel;
        int          nbytes;
        bit          tail_zlp;
        logic [1:0]  single_kind;
        t_rsp        r;
        code        = {rq.request_code, rq.request_type};
        sel         = DESC_NONE;
        nbytes      = 0;
        tail_zlp    = 1'b0;
        single_kind = KIND_STALL;
        reply_run.delete();
        case (code)
            REQ_GET_DESC: begin
                if (rq.request_value == DVAL_DEVICE) begin
                    // never clipped to wLength
                    sel    = DESC_DEVICE;
                    nbytes = 18;
                end else if (rq.request_value == DVAL_CONFIG) begin
                    sel      = DESC_CONFIG;
                    nbytes   = (rq.request_length < 32) ? rq.request_length : 32;
                    tail_zlp = (rq.request_length > 32);
                end else if ((rq.request_value & DVAL_TYPE_MSK) == DVAL_STRING) begin
                    if (rq.request_value[7:0] == STR_IDX_LANG) begin
                        sel    = DESC_LANG;
                        nbytes = 4;
                    end else if (rq.request_value[7:0] == STR_IDX_SER) begin
                        sel    = DESC_SERIAL;
                        nbytes = 26;
                    end
                end
            end
            REQ_SET_ADDR: begin
                single_kind = KIND_ZLP;
                addr_now    = rq.request_value[6:0];
                addr_on     = (rq.request_value[6:0] != 7'd0);
            end
            REQ_SET_CFG: begin
                single_kind    = KIND_ZLP;
                configured_now = 1'b1;
                eps_on         = (rq.request_value != 16'd0);
            end
            REQ_CLR_FEAT: single_kind = KIND_ZLP;
            default: single_kind = KIND_STALL;
        endcase

        r = '0;
        if (sel == DESC_NONE) begin
            r.reply_kind = single_kind;
            reply_run.push_back(r);
        end else if (nbytes == 0) begin
            // configuration clipped to nothing: data stage is one empty packet
            r.reply_kind = KIND_ZLP;
            reply_run.push_back(r);
        end else begin
            for (int i = 0; i < nbytes; i++) begin
                r.reply_kind = KIND_DATA;
                r.data_byte  = desc_byte(sel, i);
                r.packet_end = (((i + 1) % PKT_BYTES) == 0) || (i + 1 == nbytes);
                reply_run.push_back(r);
            end
            if (tail_zlp) begin
                r = '0;
                r.reply_kind = KIND_ZLP;
                reply_run.push_back(r);
            end
        end

        foreach (reply_run[k]) begin
            reply_run[k].last                  = (k == reply_run.size() - 1);
            reply_run[k].device_address_out    = addr_now;
            reply_run[k].address_enabled_out   = addr_on;
            reply_run[k].configured_out        = configured_now;
            reply_run[k].endpoints_enabled_out = eps_on;
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatches < 200)
            $display("mismatch on result %0d, %s: got %0h, expected %0h",
                     replies_seen, what, got, want);
        mismatches++;
    endtask

    task automatic check_reply(input t_rsp got);
        t_rsp want;
        replies_seen++;
        if (pending_replies.size() == 0) begin
            report_mismatch("result with nothing expected", got, 0);
            return;
        end
        want = pending_replies.pop_front();
        if (got.reply_kind != want.reply_kind)
            report_mismatch("reply_kind", got.reply_kind, want.reply_kind);
        if (got.data_byte != want.data_byte)
            report_mismatch("data_byte", got.data_byte, want.data_byte);
        if (got.packet_end != want.packet_end)
            report_mismatch("packet_end", got.packet_end, want.packet_end);
        if (got.last != want.last)
            report_mismatch("last", got.last, want.last);
        if (got.device_address_out != want.device_address_out)
            report_mismatch("device_address_out", got.device_address_out,
                            want.device_address_out);
        if (got.address_enabled_out != want.address_enabled_out)
            report_mismatch("address_enabled_out", got.address_enabled_out,
                            want.address_enabled_out);
        if (got.configured_out != want.configured_out)
            report_mismatch("configured_out", got.configured_out, want.configured_out);
        if (got.endpoints_enabled_out != want.endpoints_enabled_out)
            report_mismatch("endpoints_enabled_out", got.endpoints_enabled_out,
                            want.endpoints_enabled_out);
    endtask

    // Offer one setup item after a random gap and return at the edge that
    // accepts it. Valid stays high on return so a zero gap on the next call
    // keeps it up without a low/high pair in one step.
    task automatic send_req(input t_req rq, input bit typed, input t_rsp want);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            i_req_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_req       <= rq;
        i_req_valid <= 1'b1;
        do @(posedge i_clk); while (!o_req_ready);
        predict_reply(rq);
        if (typed)
            pending_replies.push_back(want);
        else
            foreach (reply_run[k]) pending_replies.push_back(reply_run[k]);
    endtask

    // Drop valid at the accepting edge, then hold until every owed result
    // has been taken. The block is idle afterwards.
    task automatic settle();
        i_req_valid <= 1'b0;
        do @(posedge i_clk); while (pending_replies.size() != 0);
    endtask

    // Both id registers, written back to back while idle.
    task automatic load_ids(input logic [15:0] vid, input logic [15:0] pid);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_VENDOR_ID;
        i_cfg_data <= vid;
        @(posedge i_clk);
        vid_now     = vid;
        i_cfg_idx  <= CFG_PRODUCT_ID;
        i_cfg_data <= pid;
        @(posedge i_clk);
        pid_now   = pid;
        i_cfg_we <= 1'b0;
    endtask

    // Mostly well-formed requests with random content; the rest is known
    // requests with a wrong bmRequestType and plain noise.
    function automatic t_req random_setup();
        t_req        rq;
        int          pick;
        logic [15:0] len;
        pick = $urandom_range(0, 99);
        len  = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
        if (pick < 45) begin
            case ($urandom_range(0, 5))
                0:       rq = setup(REQ_GET_DESC, DVAL_DEVICE, len);
                1, 2:    rq = setup(REQ_GET_DESC, DVAL_CONFIG, len);
                3:       rq = setup(REQ_GET_DESC, DVAL_STRING | 16'($urandom_range(0, 1)), len);
                4:       rq = setup(REQ_GET_DESC,
                                    (16'($urandom) & ~DVAL_TYPE_MSK) | DVAL_STRING, len);
                default: rq = setup(REQ_GET_DESC, 16'($urandom), len);
            endcase
        end else if (pick < 60) begin
            rq = setup(REQ_SET_ADDR, ($urandom_range(0, 1) == 0) ?
                       16'($urandom_range(0, 127)) : 16'($urandom), 16'($urandom));
        end else if (pick < 72) begin
            rq = setup(REQ_SET_CFG, ($urandom_range(0, 2) == 0) ? 16'd0 : 16'($urandom),
                       16'($urandom));
        end else if (pick < 80) begin
            rq = setup(REQ_CLR_FEAT, 16'($urandom), 16'($urandom));
        end else if (pick < 90) begin
            case ($urandom_range(0, 3))
                0:       rq = setup(REQ_GET_DESC, DVAL_DEVICE, len);
                1:       rq = setup(REQ_SET_ADDR, 16'($urandom), len);
                2:       rq = setup(REQ_SET_CFG, 16'($urandom), len);
                default: rq = setup(REQ_CLR_FEAT, 16'($urandom), len);
            endcase
            rq.request_type = 8'($urandom);
        end else begin
            rq = {$urandom, 16'($urandom)};
        end
        return rq;
    endfunction

    // Result sink: random stall before each item, one long stall on request
    // so the block backs up and holds off new setups. Valid is unknown until
    // the first reset edge, so only a clean high counts as an item.
    initial begin : rsp_sink
        int stall;
        forever begin
            if (hold_rsp_long) begin
                stall         = 150;
                hold_rsp_long = 1'b0;
            end else begin
                stall = steady ? 0 : $urandom_range(0, 4);
            end
            if (stall > 0) begin
                i_rsp_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_rsp_ready <= 1'b1;
            do @(posedge i_clk); while (o_rsp_valid !== 1'b1);
            check_reply(o_rsp);
        end
    end

    initial begin : stimulus
        t_row directed [24];

        // Rows typed in run before any state change, so status reads zero.
        directed[0]  = '{setup(REQ_GET_DESC, DVAL_DEVICE, 16'h0040), 1'b0, '0};
        directed[1]  = '{setup(REQ_GET_DESC, DVAL_CONFIG, 16'h0000), 1'b1, ZLP_AT_RESET};
        directed[2]  = '{setup(REQ_GET_DESC, DVAL_CONFIG, 16'h0009), 1'b0, '0};
        // exactly two packets: no trailing empty packet
        directed[3]  = '{setup(REQ_GET_DESC, DVAL_CONFIG, 16'h0010), 1'b0, '0};
        directed[4]  = '{setup(REQ_GET_DESC, DVAL_CONFIG, 16'h0020), 1'b0, '0};
        // host asks for more than there is: empty packet after the data
        directed[5]  = '{setup(REQ_GET_DESC, DVAL_CONFIG, 16'hFFFF), 1'b0, '0};
        directed[6]  = '{setup(REQ_GET_DESC, DVAL_STRING, 16'h00FF), 1'b0, '0};
        directed[7]  = '{setup(REQ_GET_DESC, DVAL_STRING | 16'h0001, 16'hFFFF), 1'b0, '0};
        directed[8]  = '{setup(REQ_GET_DESC, DVAL_STRING | 16'h0002, 16'h00FF), 1'b1,
                         STALL_AT_RESET};
        // type nibble matches, upper bits set: still the serial string
        directed[9]  = '{setup(REQ_GET_DESC, 16'hF301, 16'h0040), 1'b0, '0};
        directed[10] = '{setup(REQ_GET_DESC, 16'h0600, 16'h000A), 1'b1, STALL_AT_RESET};
        directed[11] = '{setup(REQ_GET_DESC, 16'hFFFF, 16'hFFFF), 1'b1, STALL_AT_RESET};
        // right bRequest, wrong direction
        directed[12] = '{setup({REQ_GET_DESC[15:8], 8'h00}, DVAL_DEVICE, 16'h0040), 1'b1,
                         STALL_AT_RESET};
        directed[13] = '{setup(16'hFFFF, 16'hFFFF, 16'hFFFF), 1'b1, STALL_AT_RESET};
        directed[14] = '{setup(16'h0000, 16'h0000, 16'h0000), 1'b1, STALL_AT_RESET};
        directed[15] = '{setup(REQ_CLR_FEAT, 16'h0000, 16'h0000), 1'b1, ZLP_AT_RESET};
        // clear feature aimed at the device instead of an interface
        directed[16] = '{setup({REQ_CLR_FEAT[15:8], 8'h00}, 16'h0000, 16'h0000), 1'b1,
                         STALL_AT_RESET};
        // configuration 0 still marks the device configured
        directed[17] = '{setup(REQ_SET_CFG, 16'h0000, 16'h0000), 1'b0, '0};
        directed[18] = '{setup(REQ_SET_CFG, 16'h0001, 16'h0000), 1'b0, '0};
        // address bits above 6 are dropped
        directed[19] = '{setup(REQ_SET_ADDR, 16'hFFFF, 16'hFFFF), 1'b0, '0};
        directed[20] = '{setup(REQ_SET_ADDR, 16'hFF80, 16'h0000), 1'b0, '0};
        directed[21] = '{setup(REQ_SET_ADDR, 16'h0005, 16'h0000), 1'b0, '0};
        directed[22] = '{setup({REQ_SET_ADDR[15:8], 8'h80}, 16'h0011, 16'h0000), 1'b0, '0};
        directed[23] = '{setup(REQ_GET_DESC, DVAL_DEVICE, 16'h0000), 1'b0, '0};

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset values of the id registers first.
        foreach (directed[n]) send_req(directed[n].rq, directed[n].typed, directed[n].want);
        settle();

        // Ids all zero; start with a gap-free burst on both sides.
        load_ids(16'h0000, 16'h0000);
        steady = 1'b1;
        repeat (12) send_req(random_setup(), 1'b0, '0);
        steady = 1'b0;
        repeat (18) send_req(random_setup(), 1'b0, '0);
        settle();

        // Ids all ones; sender pauses midway until the block has drained.
        load_ids(16'hFFFF, 16'hFFFF);
        repeat (15) send_req(random_setup(), 1'b0, '0);
        settle();
        repeat (15) send_req(random_setup(), 1'b0, '0);
        settle();

        // Random ids; sink holds off for a long stretch while setups queue up.
        load_ids(16'($urandom), 16'($urandom));
        hold_rsp_long = 1'b1;
        repeat (20) send_req(random_setup(), 1'b0, '0);
        settle();

        // Room for any stray result after the last expected one.
        repeat (40) @(posedge i_clk);
        if (mismatches == 0 && pending_replies.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Hard stop far beyond the slowest correct run.
    initial begin : watchdog
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
